// ===== hw/rtl/tlqa_pkg.sv =====
// Package for the three level order queue arbiter: transaction structs, codes,
// widths, reset capacities and default queue depths.
// No dependencies.
package tlqa_pkg;

   localparam int unsigned HIGH_DEPTH_DEF   = 8;
   localparam int unsigned MIDDLE_DEPTH_DEF = 32;
   localparam int unsigned LOW_DEPTH_DEF    = 64;

   localparam int unsigned NUM_W        = 16;
   localparam int unsigned PRIO_W       = 2;
   localparam int unsigned AHEAD_W      = 7;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CAP_W        = 7;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned HIGH_CAP_W   = 4;
   localparam int unsigned MIDDLE_CAP_W = 6;
   localparam int unsigned LOW_CAP_W    = 7;

   localparam logic [CAP_W-1:0] HIGH_CAP_RST   = 7'd5;
   localparam logic [CAP_W-1:0] MIDDLE_CAP_RST = 7'd20;
   localparam logic [CAP_W-1:0] LOW_CAP_RST    = 7'd50;

   localparam int unsigned SERVE_RATIO  = 3;
   localparam int unsigned AHEAD_MAX    = 127;
   localparam int unsigned RECIP_3      = 171;
   localparam int unsigned RECIP_W      = 8;
   localparam int unsigned RECIP_SHIFT  = 9;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_SERVE   = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_REQUEUE = 2'd3
   } kind_type;

   localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_MIDDLE = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CAP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_CAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CAP    = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0]    order_number;
      logic [PRIO_W-1:0]   served_priority;
      logic [AHEAD_W-1:0]  ahead_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ===== hw/rtl/three_level_order_queue_arbiter_unit.sv =====
// Top level of the three level order queue arbiter: order memory, queue
// pointers, serve arbitration and response register.
// Depends on tlqa_pkg.

// All three queues share one order memory of HIGH_DEPTH + MIDDLE_DEPTH +
// LOW_DEPTH entries with one write and one registered read port. Add, query,
// requeue and a serve that finds nothing answer from the idle state; a serve
// that pops an order waits in the read state for the registered read of the
// order memory. A new transaction is taken while a finished response still
// waits, provided the response register is emptied in the same cycle.
// Capacity registers may be written at any time the block is idle.
module three_level_order_queue_arbiter_unit
   import tlqa_pkg::*;
#(
   parameter int unsigned HIGH_DEPTH   = HIGH_DEPTH_DEF,
   parameter int unsigned MIDDLE_DEPTH = MIDDLE_DEPTH_DEF,
   parameter int unsigned LOW_DEPTH    = LOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]     csr_wdata
);

   localparam int unsigned MAX_HM    = (HIGH_DEPTH > MIDDLE_DEPTH) ? HIGH_DEPTH : MIDDLE_DEPTH;
   localparam int unsigned MAX_DEPTH = (MAX_HM > LOW_DEPTH) ? MAX_HM : LOW_DEPTH;
   localparam int unsigned IW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned CW        = $clog2(MAX_DEPTH + 1);
   localparam int unsigned SW        = CW + 1;
   localparam int unsigned CMW       = (CW > CAP_W) ? CW : CAP_W;
   localparam int unsigned AHW       = CW + 3;
   localparam int unsigned MULW      = CW + RECIP_W;
   localparam int unsigned TOTAL     = HIGH_DEPTH + MIDDLE_DEPTH + LOW_DEPTH;
   localparam int unsigned AW        = $clog2(TOTAL);
   localparam int unsigned DEPTH [3] = '{LOW_DEPTH, MIDDLE_DEPTH, HIGH_DEPTH};
   localparam int unsigned BASE  [3] = '{HIGH_DEPTH + MIDDLE_DEPTH, HIGH_DEPTH, 0};

   state_type            state_ff, state_in;
   logic [IW-1:0]        head_ff [3];
   logic [IW-1:0]        head_in [3];
   logic [CW-1:0]        cnt_ff [3];
   logic [CW-1:0]        cnt_in [3];
   logic [CAP_W-1:0]     cap_ff [3];
   logic [1:0]           ratio_ff, ratio_in;
   logic [NUM_W-1:0]     next_ff, next_in;
   logic                 last_valid_ff, last_valid_in;
   logic [PRIO_W-1:0]    last_prio_ff, last_prio_in;
   logic [NUM_W-1:0]     last_num_ff, last_num_in;
   logic [PRIO_W-1:0]    from_ff, from_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [NUM_W-1:0]     rd_data_ff;

   logic [NUM_W-1:0]     order_mem [TOTAL];
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [NUM_W-1:0]     wr_data;

   logic                 accept;
   logic [PRIO_W-1:0]    prio;
   logic [2:0]           full;
   logic [IW-1:0]        tail_idx [3];
   logic [IW-1:0]        prev_idx [3];
   logic [IW-1:0]        succ_idx [3];
   logic [SW-1:0]        tail_sum [3];
   logic [SW-1:0]        succ_sum [3];
   logic                 serve_found;
   logic [PRIO_W-1:0]    serve_from;
   logic [1:0]           serve_ratio;
   logic [NUM_W-1:0]     add_num;

   logic [AHW-1:0]       a_h, a_m, a_l, a_room, a_q, a_r, a_l3, a_n;
   logic [MULW-1:0]      a_prod;
   logic [AHEAD_W-1:0]   ahead;

   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign prio      = (req_data.priority_req > PRIO_HIGH) ? PRIO_HIGH : req_data.priority_req;
   assign add_num   = next_ff + NUM_W'(1);

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         full[p]     = (CMW'(cnt_ff[p]) >= CMW'(cap_ff[p])) ||
                       (CMW'(cnt_ff[p]) >= CMW'(DEPTH[p]));
         tail_sum[p] = SW'(head_ff[p]) + SW'(cnt_ff[p]);
         if (tail_sum[p] >= SW'(DEPTH[p])) begin
            tail_sum[p] = tail_sum[p] - SW'(DEPTH[p]);
         end
         tail_idx[p] = tail_sum[p][IW-1:0];
         prev_idx[p] = (head_ff[p] == '0) ? IW'(DEPTH[p] - 1) : head_ff[p] - IW'(1);
         succ_sum[p] = SW'(head_ff[p]) + SW'(1);
         succ_idx[p] = (succ_sum[p] >= SW'(DEPTH[p])) ? '0 : succ_sum[p][IW-1:0];
      end
   end

   always_comb begin
      serve_found = 1'b1;
      serve_from  = PRIO_HIGH;
      serve_ratio = ratio_ff;
      if (cnt_ff[PRIO_HIGH] != '0) begin
         serve_from = PRIO_HIGH;
      end else if (cnt_ff[PRIO_MIDDLE] != '0 && cnt_ff[PRIO_LOW] != '0) begin
         if (ratio_ff < 2'(SERVE_RATIO)) begin
            serve_from  = PRIO_MIDDLE;
            serve_ratio = ratio_ff + 2'd1;
         end else begin
            serve_from  = PRIO_LOW;
            serve_ratio = 2'd0;
         end
      end else begin
         serve_ratio = 2'd0;
         if (cnt_ff[PRIO_MIDDLE] != '0) begin
            serve_from = PRIO_MIDDLE;
         end else if (cnt_ff[PRIO_LOW] != '0) begin
            serve_from = PRIO_LOW;
         end else begin
            serve_found = 1'b0;
         end
      end
   end

   always_comb begin
      a_h    = AHW'(cnt_ff[PRIO_HIGH]);
      a_m    = AHW'(cnt_ff[PRIO_MIDDLE]);
      a_l    = AHW'(cnt_ff[PRIO_LOW]);
      a_room = AHW'(SERVE_RATIO) - AHW'(ratio_ff);
      a_prod = MULW'(cnt_ff[PRIO_MIDDLE]) * MULW'(RECIP_3);
      a_q    = AHW'(a_prod >> RECIP_SHIFT);
      a_r    = a_m - a_q * AHW'(SERVE_RATIO);
      if (a_r >= AHW'(SERVE_RATIO)) begin
         a_q = a_q + AHW'(1);
         a_r = a_r - AHW'(SERVE_RATIO);
      end
      a_l3 = a_l * AHW'(SERVE_RATIO) + a_room;
      if (prio == PRIO_HIGH) begin
         a_n = a_h;
      end else if (prio == PRIO_MIDDLE) begin
         if (a_q < a_l) begin
            a_n = a_h + a_m + a_q + ((a_r < a_room) ? AHW'(0) : AHW'(1));
         end else begin
            a_n = a_h + a_m + a_l;
         end
      end else begin
         a_n = a_h + a_l + ((a_l3 < a_m) ? a_l3 : a_m);
      end
      ahead = (a_n > AHW'(AHEAD_MAX)) ? AHEAD_W'(AHEAD_MAX) : a_n[AHEAD_W-1:0];
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            state_in = (accept && req_data.kind == KIND_SERVE && serve_found) ?
                       ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: req_ready = !rsp_valid_ff || rsp_ready;
         ST_READ: req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      ratio_in      = ratio_ff;
      next_in       = next_ff;
      last_valid_in = last_valid_ff;
      last_prio_in  = last_prio_ff;
      last_num_in   = last_num_ff;
      from_in       = from_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (state_ff == ST_READ) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in                 = '0;
         rsp_data_in.order_number    = rd_data_ff;
         rsp_data_in.served_priority = from_ff;
         rsp_data_in.status          = STATUS_OK;
         last_valid_in               = 1'b1;
         last_prio_in                = from_ff;
         last_num_in                 = rd_data_ff;
      end else if (accept) begin
         rsp_data_in = '0;
         case (req_data.kind)
            KIND_ADD: begin
               rsp_valid_in = 1'b1;
               next_in      = add_num;
               if (full[prio]) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  wr_en                    = 1'b1;
                  wr_addr                  = AW'(BASE[prio]) + AW'(tail_idx[prio]);
                  wr_data                  = add_num;
                  cnt_in[prio]             = cnt_ff[prio] + CW'(1);
                  rsp_data_in.order_number = add_num;
                  rsp_data_in.status       = STATUS_OK;
               end
            end
            KIND_SERVE: begin
               ratio_in = serve_ratio;
               if (serve_found) begin
                  rd_en              = 1'b1;
                  rd_addr            = AW'(BASE[serve_from]) + AW'(head_ff[serve_from]);
                  head_in[serve_from] = succ_idx[serve_from];
                  cnt_in[serve_from]  = cnt_ff[serve_from] - CW'(1);
                  from_in            = serve_from;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = STATUS_NONE;
                  last_valid_in      = 1'b0;
               end
            end
            KIND_QUERY: begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ahead_count = ahead;
               rsp_data_in.status      = STATUS_OK;
            end
            default: begin
               rsp_valid_in = 1'b1;
               if (!last_valid_ff) begin
                  rsp_data_in.status = STATUS_NONE;
               end else begin
                  rsp_data_in.order_number    = last_num_ff;
                  rsp_data_in.served_priority = last_prio_ff;
                  last_valid_in               = 1'b0;
                  if (full[last_prio_ff]) begin
                     rsp_data_in.status = STATUS_DROPPED;
                  end else begin
                     wr_en                 = 1'b1;
                     wr_addr               = AW'(BASE[last_prio_ff]) +
                                             AW'(prev_idx[last_prio_ff]);
                     wr_data               = last_num_ff;
                     head_in[last_prio_ff] = prev_idx[last_prio_ff];
                     cnt_in[last_prio_ff]  = cnt_ff[last_prio_ff] + CW'(1);
                     rsp_data_in.status    = STATUS_OK;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         order_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= order_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff[PRIO_HIGH]   <= HIGH_CAP_RST;
         cap_ff[PRIO_MIDDLE] <= MIDDLE_CAP_RST;
         cap_ff[PRIO_LOW]    <= LOW_CAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HIGH_CAP:   cap_ff[PRIO_HIGH]   <= CAP_W'(csr_wdata[HIGH_CAP_W-1:0]);
            CSR_MIDDLE_CAP: cap_ff[PRIO_MIDDLE] <= CAP_W'(csr_wdata[MIDDLE_CAP_W-1:0]);
            CSR_LOW_CAP:    cap_ff[PRIO_LOW]    <= CAP_W'(csr_wdata[LOW_CAP_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '{default: '0};
         cnt_ff        <= '{default: '0};
         ratio_ff      <= '0;
         next_ff       <= '0;
         last_valid_ff <= 1'b0;
         last_prio_ff  <= '0;
         last_num_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         cnt_ff        <= cnt_in;
         ratio_ff      <= ratio_in;
         next_ff       <= next_in;
         last_valid_ff <= last_valid_in;
         last_prio_ff  <= last_prio_in;
         last_num_ff   <= last_num_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff     <= from_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/sv/three_level_order_queue_arbiter_unit_tb.sv =====
// Self-checking testbench for three_level_order_queue_arbiter_unit: directed and random
// transactions with random stalls on both channels, checked against an in-bench queue model.
// Depends on tlqa_pkg and the arbiter RTL.
module three_level_order_queue_arbiter_unit_tb;
   import tlqa_pkg::*;

   localparam logic [PRIO_W-1:0] PRIO_ABOVE_HIGH = 2'd3;
   localparam int QUEUE_DEPTH [3] = '{LOW_DEPTH_DEF, MIDDLE_DEPTH_DEF, HIGH_DEPTH_DEF};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAP_W-1:0]     csr_wdata;

   // model of the queues and arbitration state
   logic [NUM_W-1:0]  waiting [3][$];
   int unsigned       cap_limit [3];
   int unsigned       middle_streak;
   logic [NUM_W-1:0]  last_issued;
   bit                last_ok;
   logic [PRIO_W-1:0] last_prio;
   logic [NUM_W-1:0]  last_num;

   rsp_type pending_responses [$];
   rsp_type want;
   int      mismatches = 0;
   bit      calm = 1'b0;

   three_level_order_queue_arbiter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic bit is_full(input int p);
      int unsigned lim;
      lim = (cap_limit[p] < QUEUE_DEPTH[p]) ? cap_limit[p] : QUEUE_DEPTH[p];
      return waiting[p].size() >= lim;
   endfunction

   function automatic logic [AHEAD_W-1:0] orders_ahead(input int p);
      int unsigned h, m, l, room, n;
      h = waiting[PRIO_HIGH].size();
      m = waiting[PRIO_MIDDLE].size();
      l = waiting[PRIO_LOW].size();
      room = SERVE_RATIO - middle_streak;
      if (p == PRIO_HIGH) begin
         n = h;
      end else if (p == PRIO_MIDDLE) begin
         n = h + m;
         if (m / SERVE_RATIO < l) begin
            n += m / SERVE_RATIO + ((m % SERVE_RATIO < room) ? 0 : 1);
         end else begin
            n += l;
         end
      end else begin
         n = h + l;
         if (l * SERVE_RATIO + room < m) begin
            n += l * SERVE_RATIO + room;
         end else begin
            n += m;
         end
      end
      if (n > AHEAD_MAX) n = AHEAD_MAX;
      return AHEAD_W'(n);
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type res;
      int      p;
      int      from;
      res = '0;
      p = (r.priority_req > PRIO_HIGH) ? PRIO_HIGH : r.priority_req;
      case (r.kind)
         KIND_ADD: begin
            last_issued = last_issued + 1'b1;
            if (is_full(p)) begin
               res.status = STATUS_FULL;
            end else begin
               waiting[p] = {waiting[p], last_issued};
               res.order_number = last_issued;
            end
         end
         KIND_SERVE: begin
            from = -1;
            if (waiting[PRIO_HIGH].size() > 0) begin
               from = PRIO_HIGH;
            end else if (waiting[PRIO_MIDDLE].size() > 0 && waiting[PRIO_LOW].size() > 0) begin
               if (middle_streak < SERVE_RATIO) begin
                  from = PRIO_MIDDLE;
                  middle_streak++;
               end else begin
                  from = PRIO_LOW;
                  middle_streak = 0;
               end
            end else begin
               middle_streak = 0;
               if (waiting[PRIO_MIDDLE].size() > 0) from = PRIO_MIDDLE;
               else if (waiting[PRIO_LOW].size() > 0) from = PRIO_LOW;
            end
            if (from < 0) begin
               res.status = STATUS_NONE;
               last_ok = 1'b0;
            end else begin
               last_num = waiting[from].pop_front();
               last_prio = PRIO_W'(from);
               last_ok = 1'b1;
               res.order_number = last_num;
               res.served_priority = last_prio;
            end
         end
         KIND_QUERY: begin
            res.ahead_count = orders_ahead(p);
         end
         default: begin
            if (!last_ok) begin
               res.status = STATUS_NONE;
            end else begin
               res.order_number = last_num;
               res.served_priority = last_prio;
               if (is_full(last_prio)) res.status = STATUS_DROPPED;
               else waiting[last_prio].push_front(last_num);
               last_ok = 1'b0;
            end
         end
      endcase
      return res;
   endfunction

   function automatic kind_type random_kind();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return KIND_ADD;
      if (pick < 75) return KIND_SERVE;
      if (pick < 90) return KIND_QUERY;
      return KIND_REQUEUE;
   endfunction

   task automatic send_item(input kind_type k, input logic [PRIO_W-1:0] p);
      int unsigned gap;
      rsp_type     expected;
      gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = '{kind: k, priority_req: p};
      do @(posedge clock); while (!req_ready);
      expected = predict_response(req_data);
      pending_responses = {pending_responses, expected};
   endtask

   // hold off until every response is back, then let the block go idle
   task automatic settle_queues();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [PRIO_W-1:0] p, input int unsigned value);
      logic [CSR_IDX_W-1:0] idx;
      int unsigned          mask;
      case (p)
         PRIO_HIGH: begin
            idx = CSR_HIGH_CAP;
            mask = (1 << HIGH_CAP_W) - 1;
         end
         PRIO_MIDDLE: begin
            idx = CSR_MIDDLE_CAP;
            mask = (1 << MIDDLE_CAP_W) - 1;
         end
         default: begin
            idx = CSR_LOW_CAP;
            mask = (1 << LOW_CAP_W) - 1;
         end
      endcase
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CAP_W'(value & mask);
      @(negedge clock);
      csr_we = 1'b0;
      cap_limit[p] = value & mask;
   endtask

   task automatic test_basic_ops();
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_REQUEUE, PRIO_LOW);
      send_item(KIND_QUERY, PRIO_LOW);
      send_item(KIND_QUERY, PRIO_MIDDLE);
      send_item(KIND_QUERY, PRIO_HIGH);
      send_item(KIND_QUERY, PRIO_ABOVE_HIGH);
      send_item(KIND_ADD, PRIO_ABOVE_HIGH);
      send_item(KIND_ADD, PRIO_HIGH);
      send_item(KIND_ADD, PRIO_MIDDLE);
      send_item(KIND_ADD, PRIO_MIDDLE);
      send_item(KIND_ADD, PRIO_LOW);
      send_item(KIND_QUERY, PRIO_LOW);
      send_item(KIND_QUERY, PRIO_MIDDLE);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_REQUEUE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_REQUEUE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_REQUEUE, PRIO_LOW);
   endtask

   task automatic test_capacity_limits();
      settle_queues();
      write_capacity(PRIO_HIGH, 1);
      write_capacity(PRIO_MIDDLE, 1);
      write_capacity(PRIO_LOW, 1);
      for (int p = PRIO_LOW; p <= PRIO_HIGH; p++) begin
         send_item(KIND_ADD, PRIO_W'(p));
         send_item(KIND_ADD, PRIO_W'(p));
      end
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_ADD, PRIO_HIGH);
      send_item(KIND_REQUEUE, PRIO_LOW);
      repeat (4) send_item(KIND_SERVE, PRIO_LOW);
      settle_queues();
      write_capacity(PRIO_LOW, 0);
      send_item(KIND_ADD, PRIO_LOW);
      settle_queues();
      write_capacity(PRIO_HIGH, 15);
      write_capacity(PRIO_MIDDLE, 63);
      write_capacity(PRIO_LOW, 127);
      repeat (HIGH_DEPTH_DEF + 1) send_item(KIND_ADD, PRIO_HIGH);
      repeat (MIDDLE_DEPTH_DEF + 1) send_item(KIND_ADD, PRIO_MIDDLE);
      repeat (LOW_DEPTH_DEF + 1) send_item(KIND_ADD, PRIO_LOW);
      for (int p = PRIO_LOW; p <= PRIO_ABOVE_HIGH; p++) send_item(KIND_QUERY, PRIO_W'(p));
      send_item(KIND_SERVE, PRIO_LOW);
      send_item(KIND_REQUEUE, PRIO_LOW);
      settle_queues();
      write_capacity(PRIO_MIDDLE, 1);
      send_item(KIND_ADD, PRIO_MIDDLE);
      repeat (QUEUE_DEPTH[0] + QUEUE_DEPTH[1] + QUEUE_DEPTH[2] + 2) begin
         send_item(KIND_SERVE, PRIO_LOW);
      end
   endtask

   task automatic test_serve_ratio();
      settle_queues();
      write_capacity(PRIO_HIGH, 5);
      write_capacity(PRIO_MIDDLE, 20);
      write_capacity(PRIO_LOW, 50);
      repeat (7) send_item(KIND_ADD, PRIO_MIDDLE);
      repeat (3) send_item(KIND_ADD, PRIO_LOW);
      repeat (11) begin
         send_item(KIND_QUERY, PRIO_MIDDLE);
         send_item(KIND_QUERY, PRIO_LOW);
         send_item(KIND_SERVE, PRIO_LOW);
      end
   endtask

   task automatic test_random_traffic(input int items);
      for (int phase = 0; phase < 4; phase++) begin
         settle_queues();
         write_capacity(PRIO_HIGH, $urandom_range(1, 15));
         write_capacity(PRIO_MIDDLE, $urandom_range(1, 63));
         write_capacity(PRIO_LOW, $urandom_range(1, 127));
         for (int i = 0; i < items / 4; i++) begin
            if (phase == 2 && i == items / 8) settle_queues();
            send_item(random_kind(), PRIO_W'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!reset && !calm && $urandom_range(0, 9) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response transaction: %p", rsp_data);
            mismatches++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.order_number !== want.order_number) begin
               $error("order_number: expected %0d, actual %0d",
                      want.order_number, rsp_data.order_number);
               mismatches++;
            end
            if (rsp_data.served_priority !== want.served_priority) begin
               $error("served_priority: expected %0d, actual %0d",
                      want.served_priority, rsp_data.served_priority);
               mismatches++;
            end
            if (rsp_data.ahead_count !== want.ahead_count) begin
               $error("ahead_count: expected %0d, actual %0d",
                      want.ahead_count, rsp_data.ahead_count);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cap_limit[PRIO_HIGH] = HIGH_CAP_RST;
      cap_limit[PRIO_MIDDLE] = MIDDLE_CAP_RST;
      cap_limit[PRIO_LOW] = LOW_CAP_RST;
      middle_streak = 0;
      last_issued = '0;
      last_ok = 1'b0;
      last_prio = '0;
      last_num = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_capacity_limits();
      test_serve_ratio();
      test_random_traffic(80);
      calm = 1'b1;
      test_random_traffic(40);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
